// ===== src/assert_macros.svh =====
// assertion macros used by the sorted list core rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/sli_pkg.sv =====
// types and constants of the sorted list table
package sli_pkg;

    localparam int InWidth  = 40;
    localparam int OutWidth = 48;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_DELETE = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_LAST,
        S_DEL,
        S_RDW,
        S_FIN
    } state_t;

endpackage

// ===== src/sli_ram.sv =====
// generic single-write, single-read ram with registered read data
module sli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/sorted_list_insert_delete_core.sv =====
// sorted list table core: insert, delete-all-equal and read by position
// usage:
//   s_axis carries one command per transfer (func, value, position); the
//   core answers every command with exactly one transfer on m_axis carrying
//   status, entry_count, removed_count and read_value.
//   entries live in one ram with a registered read port; insert and delete
//   walk the ram one entry per cycle through that single port.
// command flow:
//   insert shifts every entry above the insert position up by one; delete
//   walks all entries; read fetches one entry; full, empty and out of range
//   commands and the unused code go straight to the result.
//   one command is in work at a time; the next one is taken as soon as the
//   previous result sits in the output register.
// reset:
//   rst_n clears the entry count and all control; ram contents are left as
//   they are since no entry beyond the count is ever read.
// stall:
//   a result waits in the output register while m_axis_tready is low; a
//   finished command then waits for that register before the core goes idle.
module sorted_list_insert_delete_core #(
    parameter int CAPACITY = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // func[1:0], value[33:2], position[37:34], zero fill
    input  logic [sli_pkg::InWidth-1:0]  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // status[1:0], entry_count[6:2], removed_count[11:7], read_value[43:12], zero fill
    output logic [sli_pkg::OutWidth-1:0] m_axis_tdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 4) ? CW : 4;

    logic [1:0]         in_func;
    logic signed [31:0] in_value;
    logic [3:0]         in_position;

    sli_pkg::state_t state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      keep_reg, keep_next;
    logic [CW-1:0]      rmv_reg, rmv_next;
    logic [1:0]         status_reg, status_next;
    logic [31:0]        rdv_reg, rdv_next;
    logic signed [31:0] val_reg, val_next;
    logic               m_valid_reg, m_valid_next;
    logic [sli_pkg::OutWidth-1:0] m_data_reg, m_data_next;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [31:0]        wdata;
    logic [AW-1:0]      raddr;
    logic [31:0]        rdata;

    logic [CW-1:0]      cnt_m1, idx_m1, idx_m2, idx_p1, keep_p1, rmv_p1, cnt_p1;
    logic               accept;
    logic               out_free;

    assign in_func     = s_axis_tdata[1:0];
    assign in_value    = s_axis_tdata[33:2];
    assign in_position = s_axis_tdata[37:34];

    assign cnt_m1  = count_reg - CW'(1);
    assign cnt_p1  = count_reg + CW'(1);
    assign idx_m1  = idx_reg - CW'(1);
    assign idx_m2  = idx_reg - CW'(2);
    assign idx_p1  = idx_reg + CW'(1);
    assign keep_p1 = keep_reg + CW'(1);
    assign rmv_p1  = rmv_reg + CW'(1);

    assign s_axis_tready = (state_reg == sli_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    sli_ram #(
        .WIDTH(32),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sli_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        keep_reg   <= keep_next;
        rmv_reg    <= rmv_next;
        status_reg <= status_next;
        rdv_reg    <= rdv_next;
        val_reg    <= val_next;
        m_data_reg <= m_data_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        keep_next    = keep_reg;
        rmv_next     = rmv_reg;
        status_next  = status_reg;
        rdv_next     = rdv_reg;
        val_next     = val_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        we           = 1'b0;
        waddr        = '0;
        wdata        = val_reg;
        raddr        = '0;

        unique case (state_reg)
            sli_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    val_next    = in_value;
                    rmv_next    = '0;
                    rdv_next    = '0;
                    status_next = sli_pkg::ST_OK;
                    state_next  = sli_pkg::S_FIN;
                    unique case (in_func)
                        sli_pkg::FUNC_INSERT:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                status_next = sli_pkg::ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                we         = 1'b1;
                                waddr      = '0;
                                wdata      = in_value;
                                count_next = CW'(1);
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                raddr      = cnt_m1[AW-1:0];
                                state_next = sli_pkg::S_INS;
                            end
                        end
                        sli_pkg::FUNC_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = sli_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                idx_next   = '0;
                                keep_next  = '0;
                                raddr      = '0;
                                state_next = sli_pkg::S_DEL;
                            end
                        end
                        sli_pkg::FUNC_READ:
                        begin
                            if (PW'(in_position) < PW'(count_reg))
                            begin
                                raddr      = AW'(in_position);
                                state_next = sli_pkg::S_RDW;
                            end
                            else
                            begin
                                status_next = sli_pkg::ST_RANGE;
                            end
                        end
                        default:
                        begin
                            status_next = sli_pkg::ST_OK;
                        end
                    endcase
                end
            end
            sli_pkg::S_INS:
            begin
                // shift entries up by one until the slot for the value is found
                we    = 1'b1;
                waddr = idx_reg[AW-1:0];
                if ($signed(rdata) < val_reg)
                begin
                    wdata      = val_reg;
                    count_next = cnt_p1;
                    state_next = sli_pkg::S_FIN;
                end
                else
                begin
                    wdata = rdata;
                    if (idx_reg == CW'(1))
                    begin
                        state_next = sli_pkg::S_INS_LAST;
                    end
                    else
                    begin
                        idx_next = idx_m1;
                        raddr    = idx_m2[AW-1:0];
                    end
                end
            end
            sli_pkg::S_INS_LAST:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = val_reg;
                count_next = cnt_p1;
                state_next = sli_pkg::S_FIN;
            end
            sli_pkg::S_DEL:
            begin
                // compact kept entries toward the bottom
                if (rdata == val_reg)
                begin
                    rmv_next = rmv_p1;
                end
                else
                begin
                    we        = 1'b1;
                    waddr     = keep_reg[AW-1:0];
                    wdata     = rdata;
                    keep_next = keep_p1;
                end
                if (idx_reg == cnt_m1)
                begin
                    count_next  = keep_next;
                    status_next = (rmv_next == '0) ? sli_pkg::ST_NOT_FOUND : sli_pkg::ST_OK;
                    state_next  = sli_pkg::S_FIN;
                end
                else
                begin
                    idx_next = idx_p1;
                    raddr    = idx_p1[AW-1:0];
                end
            end
            sli_pkg::S_RDW:
            begin
                rdv_next   = rdata;
                state_next = sli_pkg::S_FIN;
            end
            sli_pkg::S_FIN:
            begin
                if (out_free)
                begin
                    m_data_next  = {4'b0000, rdv_reg, 5'(rmv_reg), 5'(count_reg), status_reg};
                    m_valid_next = 1'b1;
                    state_next   = sli_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sli_pkg::S_IDLE;
            end
        endcase
    end

    `include "assert_macros.svh"

    `ASSERT_CLK(a_count_bound, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `ASSERT_IMPL(a_write_in_range, we, waddr <= AW'(count_reg) || count_reg >= CW'(CAPACITY) || waddr == '0, "ram write beyond entry count")
    `ASSERT_IMPL(a_full_insert, accept && in_func == sli_pkg::FUNC_INSERT && count_reg >= CW'(CAPACITY), ##1 $stable(count_reg) && !we, "insert into full table changed state")
    `ASSERT_IMPL(a_idle_no_write, state_reg == sli_pkg::S_IDLE && !accept, !we, "ram write while idle")

endmodule
